/* rtl/core/tilc_pkg.sv */
// Shared constants and types for the T-intersection light controller
`default_nettype none

package tilc_pkg;

  // light colour codes
  typedef enum logic [1:0] {
    CLR_GREEN  = 2'd0,
    CLR_YELLOW = 2'd1,
    CLR_RED    = 2'd2
  } color_t;

  // configuration register indexes
  localparam int CfgIdxW = 3;
  typedef enum logic [CfgIdxW-1:0] {
    REG_ACTIVE_WAIT    = 3'd0,
    REG_INACTIVE_WAIT  = 3'd1,
    REG_YELLOW_TIME    = 3'd2,
    REG_GREEN_DELAY    = 3'd3,
    REG_MIN_MAIN_GREEN = 3'd4,
    REG_MAX_SIDE_GREEN = 3'd5
  } cfg_reg_t;

  localparam int CfgW    = 8;
  localparam int StepW   = 8;
  localparam int InDataW  = 8;
  localparam int OutDataW = 8;

  // default width of the duration and green-time counters
  localparam int CountWidthDef = 8;

  // register reset values
  localparam logic [CfgW-1:0] RstActiveWait   = 8'd10;
  localparam logic [CfgW-1:0] RstInactiveWait = 8'd5;
  localparam logic [CfgW-1:0] RstYellowTime   = 8'd3;
  localparam logic [CfgW-1:0] RstGreenDelay   = 8'd5;
  localparam logic [CfgW-1:0] RstMinMainGreen = 8'd30;
  localparam logic [CfgW-1:0] RstMaxSideGreen = 8'd40;

endpackage : tilc_pkg

`default_nettype wire

/* rtl/core/t_intersection_light_controller.sv */
// An input transaction reaches out_tvalid through the input register, then the result register.
// Throughput: one tick per cycle unless stalled; sequencer state and counters update in one pass.
// A result waiting in the output register holds the step; the input register still takes one
// transaction, after which in_tready stays low until the result is taken.
// Reset (synchronous, rst_n low): main green, side red, counters at one, no sequence,
// registers at their defaults (10, 5, 3, 5, 30, 40).
`default_nettype none

module t_intersection_light_controller #(
  parameter int COUNT_WIDTH = tilc_pkg::CountWidthDef
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input stream: [0] sensor_present, [7:1] zero
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [tilc_pkg::InDataW-1:0]   in_tdata,
  // result stream: [1:0] main_color, [3:2] side_color, [4] changing, [5] forced, [7:6] zero
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [tilc_pkg::OutDataW-1:0]       out_tdata,
  // configuration write channel
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tilc_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [tilc_pkg::CfgW-1:0]      cfg_data
);

  import tilc_pkg::*;

  // compare width covers both counters and 8-bit registers
  localparam int CmpW = (COUNT_WIDTH > CfgW) ? COUNT_WIDTH : CfgW;
  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] CountOne = COUNT_WIDTH'(1);
  localparam logic [StepW-1:0]       StepMax  = {StepW{1'b1}};

  // configuration registers
  logic [CfgW-1:0] active_wait_r, inactive_wait_r, yellow_time_r, green_delay_r;
  logic [CfgW-1:0] min_main_green_r, max_side_green_r;

  // input stage
  logic in_valid_r, sensor_r;

  // controller state
  logic                   sensor_level_r, sensor_level_nxt;
  logic [COUNT_WIDTH-1:0] sensor_count_r, sensor_count_nxt;
  color_t                 main_light_r, main_light_nxt;
  color_t                 side_light_r, side_light_nxt;
  logic [COUNT_WIDTH-1:0] main_cnt_r, main_cnt_nxt;
  logic [COUNT_WIDTH-1:0] side_cnt_r, side_cnt_nxt;
  logic                   seq_active_r, seq_active_nxt;
  logic                   seq_to_side_r, seq_to_side_nxt;
  logic [StepW-1:0]       seq_step_r, seq_step_nxt;
  logic                   forced_nxt;

  // result register
  logic                   out_valid_r;
  logic [OutDataW-1:0]    out_data_r;

  logic                   step_en;
  logic                   in_acc;

  // handshakes: result register frees on take, input register on step
  assign step_en   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step_en;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // one tick of the controller
  always_comb begin
    logic [COUNT_WIDTH-1:0] sc0;
    logic                   main_ok, side_ok;
    logic [StepW-1:0]       last;
    color_t                 lose_l, win_l;
    logic [COUNT_WIDTH-1:0] lose_c, win_c;
    logic                   win_painted;

    sensor_level_nxt = sensor_level_r;
    sc0              = sensor_count_r;
    if (sensor_r != sensor_level_r) begin
      sensor_level_nxt = sensor_r;
      sc0              = CountOne;
    end

    main_light_nxt  = main_light_r;
    side_light_nxt  = side_light_r;
    main_cnt_nxt    = main_cnt_r;
    side_cnt_nxt    = side_cnt_r;
    seq_active_nxt  = seq_active_r;
    seq_to_side_nxt = seq_to_side_r;
    seq_step_nxt    = seq_step_r;
    forced_nxt      = 1'b0;

    main_ok = (main_light_r != CLR_GREEN) ||
              (CmpW'(main_cnt_r) > CmpW'(min_main_green_r));
    side_ok = (side_light_r != CLR_GREEN) ||
              (CmpW'(side_cnt_r) <= CmpW'(max_side_green_r));

    // sequence start decision
    if (seq_active_r || !main_ok || !side_ok) begin
      if (!side_ok) begin
        main_cnt_nxt    = CountOne;
        side_cnt_nxt    = CountOne;
        seq_active_nxt  = 1'b1;
        seq_to_side_nxt = 1'b0;
        seq_step_nxt    = '0;
        forced_nxt      = 1'b1;
      end
    end else if (sensor_level_nxt) begin
      if ((CmpW'(sc0) > CmpW'(active_wait_r)) && (main_light_r == CLR_GREEN) &&
          (side_light_r == CLR_RED)) begin
        seq_active_nxt  = 1'b1;
        seq_to_side_nxt = 1'b1;
        seq_step_nxt    = '0;
      end
    end else begin
      if ((CmpW'(sc0) > CmpW'(inactive_wait_r)) && (main_light_r == CLR_RED) &&
          (side_light_r == CLR_GREEN)) begin
        seq_active_nxt  = 1'b1;
        seq_to_side_nxt = 1'b0;
        seq_step_nxt    = '0;
      end
    end

    sensor_count_nxt = (sc0 == CountMax) ? sc0 : sc0 + CountOne;

    // sequence step: loser yellow then red, winner green
    lose_l = seq_to_side_nxt ? main_light_nxt : side_light_nxt;
    lose_c = seq_to_side_nxt ? main_cnt_nxt   : side_cnt_nxt;
    win_l  = seq_to_side_nxt ? side_light_nxt : main_light_nxt;
    win_c  = seq_to_side_nxt ? side_cnt_nxt   : main_cnt_nxt;
    win_painted = 1'b0;
    last = (yellow_time_r > green_delay_r) ? yellow_time_r : green_delay_r;
    if (seq_active_nxt) begin
      if (seq_step_nxt == yellow_time_r) begin
        lose_l = CLR_RED;
      end else if (seq_step_nxt == '0) begin
        lose_l = CLR_YELLOW;
      end
      if (seq_step_nxt == green_delay_r) begin
        win_l       = CLR_GREEN;
        win_painted = 1'b1;
      end
      if (win_painted) begin
        win_c = CountOne;
      end
      if (seq_step_nxt >= last) begin
        seq_active_nxt = 1'b0;
      end else if (seq_step_nxt != StepMax) begin
        seq_step_nxt = seq_step_nxt + StepW'(1);
      end
      if (seq_to_side_nxt) begin
        main_light_nxt = lose_l;
        main_cnt_nxt   = lose_c;
        side_light_nxt = win_l;
        side_cnt_nxt   = win_c;
      end else begin
        side_light_nxt = lose_l;
        side_cnt_nxt   = lose_c;
        main_light_nxt = win_l;
        main_cnt_nxt   = win_c;
      end
    end

    // green-time counting
    if ((main_light_nxt == CLR_GREEN) && (main_cnt_nxt != CountMax)) begin
      main_cnt_nxt = main_cnt_nxt + CountOne;
    end
    if ((side_light_nxt == CLR_GREEN) && (side_cnt_nxt != CountMax)) begin
      side_cnt_nxt = side_cnt_nxt + CountOne;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_wait_r    <= RstActiveWait;
      inactive_wait_r  <= RstInactiveWait;
      yellow_time_r    <= RstYellowTime;
      green_delay_r    <= RstGreenDelay;
      min_main_green_r <= RstMinMainGreen;
      max_side_green_r <= RstMaxSideGreen;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_ACTIVE_WAIT:    active_wait_r    <= cfg_data;
        REG_INACTIVE_WAIT:  inactive_wait_r  <= cfg_data;
        REG_YELLOW_TIME:    yellow_time_r    <= cfg_data;
        REG_GREEN_DELAY:    green_delay_r    <= cfg_data;
        REG_MIN_MAIN_GREEN: min_main_green_r <= cfg_data;
        REG_MAX_SIDE_GREEN: max_side_green_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sensor_r <= in_tdata[0];
    end
  end

  // controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_level_r <= 1'b0;
      sensor_count_r <= CountOne;
      main_light_r   <= CLR_GREEN;
      side_light_r   <= CLR_RED;
      main_cnt_r     <= CountOne;
      side_cnt_r     <= CountOne;
      seq_active_r   <= 1'b0;
      seq_to_side_r  <= 1'b0;
      seq_step_r     <= '0;
    end else if (step_en) begin
      sensor_level_r <= sensor_level_nxt;
      sensor_count_r <= sensor_count_nxt;
      main_light_r   <= main_light_nxt;
      side_light_r   <= side_light_nxt;
      main_cnt_r     <= main_cnt_nxt;
      side_cnt_r     <= side_cnt_nxt;
      seq_active_r   <= seq_active_nxt;
      seq_to_side_r  <= seq_to_side_nxt;
      seq_step_r     <= seq_step_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_data_r <= {2'b00, forced_nxt, seq_active_nxt, side_light_nxt, main_light_nxt};
    end
  end

endmodule : t_intersection_light_controller

`default_nettype wire
